### design/ffsd_pkg.sv
// Shared types, constants and state codes for the flex-fuel sensor decoder.
`timescale 1ns / 1ps
package ffsd_pkg;

    // Numerator 2*T + p stays below 2^33 for every tick rate in range (2*T < 2^28).
    localparam int DIV_W  = 33;
    localparam int DIV_CW = $clog2(DIV_W);

    localparam int TICKS_PER_SECOND_DEF = 1000000;

    // floor(y / 100) == (y * RECIP_M) >> RECIP_SH for every y below 2^20
    localparam int          RECIP_SH  = 27;
    localparam logic [20:0] RECIP_M   = 21'd1342178;
    localparam logic [20:0] ROUND_ADD = 21'd50;

    localparam logic [19:0] TEMP_BIAS = 20'd8125;
    localparam logic [14:0] DAC_MAX   = 15'd4095;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_OFFSET   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LIMIT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_OFFSET    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_SPAN      = 4'd3;

    localparam logic [7:0]  FREQ_OFFSET_RST   = 8'd50;
    localparam logic [7:0]  CONTENT_LIMIT_RST = 8'd150;
    localparam logic [11:0] DAC_OFFSET_RST    = 12'd410;
    localparam logic [11:0] DAC_SPAN_RST      = 12'd3275;

    typedef struct packed {
        logic        rise_edge;
        logic        fall_edge;
        logic [31:0] timestamp_us;
    } t_in;

    typedef struct packed {
        logic [7:0]         ethanol_percent;
        logic signed [19:0] temperature_centi;
        logic [31:0]        period_ticks;
        logic [11:0]        dac_code;
        logic [7:0]         dac_byte_one;
        logic [7:0]         dac_byte_two;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CONT,
        ST_MUL_CS,
        ST_MUL_RC,
        ST_FIN
    } t_state;

endpackage

### design/flex_fuel_sensor_decoder.sv
// Top level of the flex-fuel sensor decoder: edge bookkeeping, sequencer, DAC scaling.
//
// Input beats carry rise_edge, fall_edge and a wrapping microsecond timestamp.
// A rise updates the rise-to-rise period and the rise time; a fall updates the
// fuel temperature from the high time (rise handled first when both are set).
// Every input beat yields exactly one output beat: ethanol percent, stored
// temperature and period, clamped DAC code and its two I2C data bytes.
// The period goes through a 33-step restoring divider, then one shared
// multiplier runs twice (content * span, then the reciprocal of 100).
// The block takes no new item until the result of the last one is loaded.
// o_stall is high from acceptance until the result is loaded into the output
// register. If the receiver holds i_stall while an older result still waits,
// the new result is held in the last step until the output register frees.
// Configuration writes land at once and must only be made while idle.
// Synchronous reset returns the configuration registers to their defaults and clears the stored
// rise time, period and temperature.
`timescale 1ns / 1ps
module flex_fuel_sensor_decoder #(
    parameter int TICKS_PER_SECOND = ffsd_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  ffsd_pkg::t_in                   i_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output ffsd_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [ffsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffsd_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam logic [ffsd_pkg::DIV_W-1:0] NUM_BIAS = ffsd_pkg::DIV_W'(2 * TICKS_PER_SECOND);

    ffsd_pkg::t_state r_state, n_state;

    logic [7:0]         r_freq_offset;
    logic [7:0]         r_content_limit;
    logic [11:0]        r_dac_offset;
    logic [11:0]        r_dac_span;

    logic [31:0]        r_last_rise, n_last_rise;
    logic [31:0]        r_period, n_period;
    logic [19:0]        r_temp, n_temp;
    logic [7:0]         r_content;
    logic [41:0]        r_prod;

    logic               r_out_valid;
    ffsd_pkg::t_out     r_out;

    logic               w_in_accept;
    logic               w_out_load;
    logic [31:0]        w_base;
    logic [31:0]        w_high;
    logic [15:0]        w_hsat;
    logic [21:0]        w_t33;

    logic [ffsd_pkg::DIV_W-1:0] w_div_num;
    logic [ffsd_pkg::DIV_W-1:0] w_quot;
    logic               w_div_done;
    logic [ffsd_pkg::DIV_W-1:0] w_off33;
    logic [ffsd_pkg::DIV_W-1:0] w_qdiff;
    logic               w_cont_ok;

    logic [20:0]        w_mul_a;
    logic [20:0]        w_mul_b;

    logic [14:0]        w_code;
    logic [14:0]        w_top;
    logic [14:0]        w_clamp;
    logic [11:0]        w_dac;

    assign w_in_accept = i_valid && (r_state == ffsd_pkg::ST_IDLE);
    assign o_stall     = (r_state != ffsd_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;

    // Edge bookkeeping
    assign w_base = i_in.rise_edge ? i_in.timestamp_us : r_last_rise;
    assign w_high = i_in.timestamp_us - w_base;
    assign w_hsat = (|w_high[31:16]) ? 16'hFFFF : w_high[15:0];
    assign w_t33  = {1'b0, w_hsat, 5'b0} + {6'b0, w_hsat};

    always_comb begin
        n_last_rise = r_last_rise;
        n_period    = r_period;
        n_temp      = r_temp;
        if (w_in_accept) begin
            if (i_in.rise_edge) begin
                n_period    = i_in.timestamp_us - r_last_rise;
                n_last_rise = i_in.timestamp_us;
            end
            if (i_in.fall_edge) begin
                n_temp = {1'b0, w_t33[21:3]} - ffsd_pkg::TEMP_BIAS;
            end
        end
    end

    // Rounded frequency: (2T + p) / (2p)
    assign w_div_num = NUM_BIAS + ffsd_pkg::DIV_W'(n_period);

    ffsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_accept),
        .i_num   (w_div_num),
        .i_den   ({r_period, 1'b0}),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_off33   = ffsd_pkg::DIV_W'(r_freq_offset);
    assign w_qdiff   = w_quot - w_off33;
    assign w_cont_ok = (r_period != '0) && (w_quot >= w_off33)
                       && (w_qdiff <= ffsd_pkg::DIV_W'(r_content_limit));

    // Shared multiplier: content * span, then (product + 50) * reciprocal of 100
    assign w_mul_a = (r_state == ffsd_pkg::ST_MUL_RC) ? (r_prod[20:0] + ffsd_pkg::ROUND_ADD)
                                                      : {13'b0, r_content};
    assign w_mul_b = (r_state == ffsd_pkg::ST_MUL_RC) ? ffsd_pkg::RECIP_M
                                                      : {9'b0, r_dac_span};

    assign w_code  = r_prod[ffsd_pkg::RECIP_SH +: 15] + 15'(r_dac_offset);
    assign w_top   = 15'(r_dac_offset) + 15'(r_dac_span);
    assign w_clamp = (w_code > w_top) ? w_top : w_code;
    assign w_dac   = (w_clamp > ffsd_pkg::DAC_MAX) ? 12'hFFF : w_clamp[11:0];

    assign w_out_load = (r_state == ffsd_pkg::ST_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffsd_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ffsd_pkg::ST_DIV;
                end
            end
            ffsd_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = ffsd_pkg::ST_CONT;
                end
            end
            ffsd_pkg::ST_CONT:   n_state = ffsd_pkg::ST_MUL_CS;
            ffsd_pkg::ST_MUL_CS: n_state = ffsd_pkg::ST_MUL_RC;
            ffsd_pkg::ST_MUL_RC: n_state = ffsd_pkg::ST_FIN;
            ffsd_pkg::ST_FIN: begin
                if (w_out_load) begin
                    n_state = ffsd_pkg::ST_IDLE;
                end
            end
            default: n_state = ffsd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_offset   <= ffsd_pkg::FREQ_OFFSET_RST;
            r_content_limit <= ffsd_pkg::CONTENT_LIMIT_RST;
            r_dac_offset    <= ffsd_pkg::DAC_OFFSET_RST;
            r_dac_span      <= ffsd_pkg::DAC_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ffsd_pkg::CFG_FREQ_OFFSET:   r_freq_offset   <= i_cfg_data[7:0];
                ffsd_pkg::CFG_CONTENT_LIMIT: r_content_limit <= i_cfg_data[7:0];
                ffsd_pkg::CFG_DAC_OFFSET:    r_dac_offset    <= i_cfg_data;
                ffsd_pkg::CFG_DAC_SPAN:      r_dac_span      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rise <= '0;
            r_period    <= '0;
            r_temp      <= '0;
        end else begin
            r_last_rise <= n_last_rise;
            r_period    <= n_period;
            r_temp      <= n_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ffsd_pkg::ST_CONT) begin
            r_content <= w_cont_ok ? w_qdiff[7:0] : 8'd0;
        end
        if (r_state == ffsd_pkg::ST_MUL_CS || r_state == ffsd_pkg::ST_MUL_RC) begin
            r_prod <= w_mul_a * w_mul_b;
        end
    end

    // Hold the result until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.ethanol_percent   <= r_content;
            r_out.temperature_centi <= r_temp;
            r_out.period_ticks      <= r_period;
            r_out.dac_code          <= w_dac;
            r_out.dac_byte_one      <= {w_dac[3:0], 4'b0};
            r_out.dac_byte_two      <= w_dac[11:4];
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ffsd_pkg::ST_DIV))
        else $error("sequencer did not start the divide after an accepted beat");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ffsd_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ffsd_pkg::ST_FIN))
        else $error("result loaded outside the final step");

    a_state_stable_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ffsd_pkg::ST_IDLE) |=> $stable(r_period) && $stable(r_last_rise))
        else $error("edge state changed while an item was in flight");

endmodule

### design/ffsd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ffsd_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ffsd_pkg::DIV_W-1:0] i_num,
    input  logic [ffsd_pkg::DIV_W-1:0] i_den,
    output logic                    o_done,
    output logic [ffsd_pkg::DIV_W-1:0] o_quot
);

    logic                        r_busy;
    logic [ffsd_pkg::DIV_CW-1:0] r_cnt;
    logic [ffsd_pkg::DIV_W-1:0]  r_rem;
    logic [ffsd_pkg::DIV_W-1:0]  r_num;

    logic [ffsd_pkg::DIV_W:0]    w_rem_sh;
    logic [ffsd_pkg::DIV_W:0]    w_diff;
    logic                        w_qbit;

    assign w_rem_sh = {r_rem, r_num[ffsd_pkg::DIV_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, i_den};
    assign w_qbit   = (w_rem_sh >= {1'b0, i_den});

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= ffsd_pkg::DIV_CW'(ffsd_pkg::DIV_W - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient bits shift in behind the numerator bits as they leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[ffsd_pkg::DIV_W-1:0] : w_rem_sh[ffsd_pkg::DIV_W-1:0];
            r_num <= {r_num[ffsd_pkg::DIV_W-2:0], w_qbit};
        end
    end

endmodule

### verif/tb.sv
// Self-checking testbench for the flex-fuel sensor decoder: edge beats, settings, idling and receiver stalls.
`timescale 1ns / 1ps
module tb;

    localparam int TICKS = ffsd_pkg::TICKS_PER_SECOND_DEF;
    // No register lives at this index; writes to it must be dropped.
    localparam logic [ffsd_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 4'd15;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    ffsd_pkg::t_in                  i_in        = '0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    ffsd_pkg::t_out                 o_out;
    logic                           i_cfg_we    = 1'b0;
    logic [ffsd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ffsd_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    flex_fuel_sensor_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirrors of the registers and of the edge bookkeeping
    logic [7:0]         r_freq_off = ffsd_pkg::FREQ_OFFSET_RST;
    logic [7:0]         r_limit    = ffsd_pkg::CONTENT_LIMIT_RST;
    logic [11:0]        r_off      = ffsd_pkg::DAC_OFFSET_RST;
    logic [11:0]        r_span     = ffsd_pkg::DAC_SPAN_RST;
    logic [31:0]        m_rise_at  = '0;
    logic [31:0]        m_period   = '0;
    logic signed [19:0] m_temp     = '0;

    ffsd_pkg::t_in  edges_pending[$];
    ffsd_pkg::t_out readings_due[$];
    int   fails         = 0;
    int   snd_idle_pct  = 0;
    int   rcv_stall_pct = 0;
    bit   beat_taken    = 1'b0;

    task automatic predict_reading(input ffsd_pkg::t_in b);
        logic [31:0]    high_us;
        int             centi;
        longint         per, q, content, code, top;
        ffsd_pkg::t_out r;
        if (b.rise_edge) begin
            m_period  = b.timestamp_us - m_rise_at;
            m_rise_at = b.timestamp_us;
        end
        // rise already handled, so both edges together give a zero high time
        if (b.fall_edge) begin
            high_us = b.timestamp_us - m_rise_at;
            if (high_us > 32'd65535) high_us = 32'd65535;
            centi  = int'((33 * high_us) >> 3) - 8125;
            m_temp = centi[19:0];
        end
        per     = longint'(m_period);
        content = 0;
        if (per != 0) begin
            q       = (2 * longint'(TICKS) + per) / (2 * per);
            content = q - longint'(r_freq_off);
            if (content < 0 || content > longint'(r_limit)) content = 0;
        end
        code = (2 * content * longint'(r_span) + 100) / 200 + longint'(r_off);
        top  = longint'(r_off) + longint'(r_span);
        if (code > top) code = top;
        if (code > longint'(ffsd_pkg::DAC_MAX)) code = longint'(ffsd_pkg::DAC_MAX);
        r.ethanol_percent   = content[7:0];
        r.temperature_centi = m_temp;
        r.period_ticks      = m_period;
        r.dac_code          = code[11:0];
        r.dac_byte_one      = {code[3:0], 4'b0000};
        r.dac_byte_two      = code[11:4];
        readings_due.push_back(r);
    endtask

    task automatic cmp_field(input string what, input longint want, input longint got);
        if (want != got) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic add_beat(input bit rise, input bit fall, input logic [31:0] ts);
        ffsd_pkg::t_in b;
        b.rise_edge    = rise;
        b.fall_edge    = fall;
        b.timestamp_us = ts;
        edges_pending.push_back(b);
    endtask

    task automatic write_reg(input logic [ffsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ffsd_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            ffsd_pkg::CFG_FREQ_OFFSET:   r_freq_off = val[7:0];
            ffsd_pkg::CFG_CONTENT_LIMIT: r_limit    = val[7:0];
            ffsd_pkg::CFG_DAC_OFFSET:    r_off      = val;
            ffsd_pkg::CFG_DAC_SPAN:      r_span     = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        while (edges_pending.size() != 0 || readings_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Driver: new beats and stall decisions at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            // hold a beat that has not gone through yet
            if (!i_valid || beat_taken) begin
                if (edges_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    i_valid <= 1'b1;
                    i_in    <= edges_pending[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Monitor: predict on accepted input beats, check accepted result beats
    always @(posedge i_clk) begin : mon
        ffsd_pkg::t_out want;
        beat_taken = i_rst_n && i_valid && !o_stall;
        if (beat_taken) begin
            predict_reading(i_in);
            void'(edges_pending.pop_front());
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (readings_due.size() == 0) begin
                fails++;
                $display("%0t: result beat with nothing expected, got %h", $time, o_out);
            end else begin
                want = readings_due.pop_front();
                cmp_field("ethanol_percent", want.ethanol_percent, o_out.ethanol_percent);
                cmp_field("temperature_centi", want.temperature_centi,
                          o_out.temperature_centi);
                cmp_field("period_ticks", want.period_ticks, o_out.period_ticks);
                cmp_field("dac_code", want.dac_code, o_out.dac_code);
                cmp_field("dac_byte_one", want.dac_byte_one, o_out.dac_byte_one);
                cmp_field("dac_byte_two", want.dac_byte_two, o_out.dac_byte_two);
            end
        end
    end

    initial begin
        logic [31:0] gen_rise, ts, per, hi;
        logic [11:0] fo, cl, dof, dsp;
        bit          want_rise, nr, nf;
        int          k;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed beats under reset settings
        add_beat(1'b0, 1'b0, 32'd0);            // no edge, zero period
        add_beat(1'b0, 1'b1, 32'd1000);
        add_beat(1'b1, 1'b0, 32'd20000);        // 50 Hz, content zero
        add_beat(1'b0, 1'b1, 32'd85535);        // high time right at saturation
        add_beat(1'b0, 1'b1, 32'd120000);       // high time beyond saturation
        add_beat(1'b0, 1'b1, 32'd20000);        // zero high time
        add_beat(1'b1, 1'b0, 32'd30000);        // 100 Hz
        add_beat(1'b1, 1'b1, 32'd36667);        // both edges, content 100
        add_beat(1'b1, 1'b0, 32'd41667);        // content at the limit
        add_beat(1'b1, 1'b0, 32'd46642);        // one above the limit
        add_beat(1'b1, 1'b0, 32'd46642);        // zero period
        add_beat(1'b1, 1'b0, 32'd62642);        // frequency exactly half way
        add_beat(1'b1, 1'b0, 32'd62643);        // period of one
        add_beat(1'b1, 1'b0, 32'd62642);        // period wraps to all ones
        add_beat(1'b1, 1'b0, 32'hFFFF_FFF0);
        add_beat(1'b1, 1'b0, 32'd19312);        // wraps; DAC scaling half way
        add_beat(1'b0, 1'b1, 32'd21312);
        add_beat(1'b0, 1'b0, 32'hFFFF_FFFF);
        add_beat(1'b1, 1'b0, 32'd28836);
        wait_drain();

        gen_rise  = 32'hFFF0_0000;
        want_rise = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    fo = 12'(ffsd_pkg::FREQ_OFFSET_RST);
                    cl = 12'(ffsd_pkg::CONTENT_LIMIT_RST);
                    dof = ffsd_pkg::DAC_OFFSET_RST; dsp = ffsd_pkg::DAC_SPAN_RST;
                end
                1: begin fo = 12'd0;   cl = 12'd255; dof = 12'd0;    dsp = 12'd4095; end
                2: begin fo = 12'hFFF; cl = 12'd0;   dof = 12'd4095; dsp = 12'd4095; end
                3: begin
                    fo = 12'($urandom_range(80)); cl = 12'($urandom_range(255, 60));
                    dof = 12'($urandom_range(1000)); dsp = 12'($urandom_range(4095, 1000));
                end
                4: begin fo = 12'hF1E; cl = 12'h0C8; dof = 12'd3000; dsp = 12'd2000; end
                default: begin
                    fo = 12'($urandom_range(4095)); cl = 12'($urandom_range(4095));
                    dof = 12'($urandom_range(4095)); dsp = 12'($urandom_range(4095));
                end
            endcase
            write_reg(ffsd_pkg::CFG_FREQ_OFFSET, fo);
            write_reg(ffsd_pkg::CFG_CONTENT_LIMIT, cl);
            write_reg(ffsd_pkg::CFG_DAC_OFFSET, dof);
            write_reg(ffsd_pkg::CFG_DAC_SPAN, dsp);
            write_reg(CFG_IDX_NONE, 12'($urandom_range(4095)));
            write_reg(4'($urandom_range(CFG_IDX_NONE, ffsd_pkg::CFG_DAC_SPAN + 1)),
                      12'($urandom_range(4095)));

            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 54; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 54; end
                default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
            endcase

            for (int n = 0; n < 240; n++) begin
                k = $urandom_range(99);
                if (k < 75) begin
                    // alternating pulse train: a rise, then a fall a random high time after it
                    if (want_rise) begin
                        k = $urandom_range(99);
                        if (k < 60)      per = $urandom_range(21000, 6000);
                        else if (k < 80) per = $urandom_range(6000, 1);
                        else if (k < 88) per = $urandom_range(2000000, 21000);
                        else if (k < 94) per = $urandom();
                        else             per = '0;
                        gen_rise += per;
                        add_beat(1'b1, 1'b0, gen_rise);
                    end else begin
                        k = $urandom_range(99);
                        if (k < 70)      hi = $urandom_range(5000, 500);
                        else if (k < 85) hi = $urandom_range(70000, 0);
                        else if (k < 95) hi = 32'd65534 + $urandom_range(2);
                        else             hi = $urandom();
                        add_beat(1'b0, 1'b1, gen_rise + hi);
                    end
                    want_rise = !want_rise;
                end else begin
                    ts = (k < 85) ? $urandom() : gen_rise + $urandom_range(200000);
                    nr = 1'($urandom_range(1));
                    nf = 1'($urandom_range(1));
                    if (k >= 95) begin
                        nr = 1'b1;
                        nf = 1'b1;
                    end
                    if (nr) gen_rise = ts;
                    add_beat(nr, nf, ts);
                end
            end
            wait_drain();
        end

        repeat (60) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
design/ffsd_pkg.sv
design/ffsd_div.sv
design/flex_fuel_sensor_decoder.sv
verif/tb.sv
